@@ hw/rtl/hke_pkg.sv @@
// Shared types, constants and corner tables for the Hilbert key encoder.
// No dependencies; used by hke_cell and hilbert_key_encoder_unit.
package hke_pkg;

    localparam int KEY_W = 48;
    localparam int NUM_AXES = 3;
    localparam int NUM_CORNERS = 8;

    typedef enum logic [2:0] {
        REG_DIMENSIONS  = 3'd0,
        REG_LEVEL_COUNT = 3'd1,
        REG_MIN_X       = 3'd2,
        REG_MIN_Y       = 3'd3,
        REG_MIN_Z       = 3'd4,
        REG_MAX_X       = 3'd5,
        REG_MAX_Y       = 3'd6,
        REG_MAX_Z       = 3'd7
    } hke_reg_t;

    // Per-item control that travels down the chain with the coordinates.
    typedef struct packed {
        logic                        valid;
        logic [NUM_CORNERS-1:0][2:0] mask;
        logic [KEY_W-1:0]            key;
    } hke_ctrl_t;

    localparam logic [2:0] SUB1 [2][2] = '{'{3'd0, 3'd1}, '{3'd0, 3'd1}};
    localparam logic [2:0] SUB2 [4][4] = '{
        '{3'd0, 3'd3, 3'd2, 3'd1}, '{3'd0, 3'd1, 3'd2, 3'd3},
        '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd2, 3'd1, 3'd0, 3'd3}
    };
    localparam logic [2:0] SUB3 [8][8] = '{
        '{3'd0, 3'd7, 3'd4, 3'd3, 3'd2, 3'd5, 3'd6, 3'd1},
        '{3'd0, 3'd1, 3'd6, 3'd7, 3'd4, 3'd5, 3'd2, 3'd3},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd6, 3'd1, 3'd0, 3'd7, 3'd4, 3'd3, 3'd2, 3'd5},
        '{3'd2, 3'd5, 3'd4, 3'd3, 3'd0, 3'd7, 3'd6, 3'd1},
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd4, 3'd5, 3'd2, 3'd3, 3'd0, 3'd1, 3'd6, 3'd7},
        '{3'd6, 3'd1, 3'd2, 3'd5, 3'd4, 3'd3, 3'd0, 3'd7}
    };
    localparam logic [2:0] HIGH1 [2] = '{3'd0, 3'd1};
    localparam logic [2:0] HIGH2 [4] = '{3'd0, 3'd2, 3'd3, 3'd1};
    localparam logic [2:0] HIGH3 [8] = '{3'd0, 3'd4, 3'd5, 3'd1, 3'd3, 3'd7, 3'd6, 3'd2};

    // Corner of the old box paired with chosen corner q to form new corner i.
    function automatic logic [2:0] sub_entry(logic [1:0] dims, logic [2:0] q, logic [2:0] i);
        logic [2:0] r;
        unique case (dims)
            2'd1:    r = SUB1[q[0]][i[0]];
            2'd2:    r = SUB2[q[1:0]][i[1:0]];
            2'd3:    r = SUB3[q][i];
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Axes of initial corner i that take the upper bound.
    function automatic logic [2:0] high_mask(logic [1:0] dims, logic [2:0] i);
        logic [2:0] r;
        unique case (dims)
            2'd1:    r = HIGH1[i[0]];
            2'd2:    r = HIGH2[i[1:0]];
            2'd3:    r = HIGH3[i];
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/hke_cell.sv @@
// One refinement level: nearest corner pick, key digit, sub-box update.
// Depends on hke_pkg.
module hke_cell #(
    parameter int VW        = 48,
    parameter int LEVEL_IDX = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [1:0]            dims,
    input  logic [4:0]            levels,
    input  hke_pkg::hke_ctrl_t    ctrl_in,
    input  logic [2:0][VW-1:0]    pt_in,
    input  logic [2:0][VW-1:0]    lo_in,
    input  logic [2:0][VW-1:0]    hi_in,
    output hke_pkg::hke_ctrl_t    ctrl_reg,
    output logic [2:0][VW-1:0]    pt_reg,
    output logic [2:0][VW-1:0]    lo_reg,
    output logic [2:0][VW-1:0]    hi_reg
);

    logic               active;
    logic [3:0]         n_val;
    logic [2:0][VW:0]   dl, dh, dlo, dhi;
    logic [2:0]         ok_lo, ok_hi;
    logic [7:0]         hit;
    logic [2:0]         q;
    logic [2:0]         mq, jj;
    logic [2:0][VW-1:0] vv, ww;
    logic [2:0][VW:0]   sum;
    hke_pkg::hke_ctrl_t ctrl_next;
    logic [2:0][VW-1:0] lo_next, hi_next;

    assign active = (5'(LEVEL_IDX) < levels) && (dims != 2'd0);
    assign n_val  = 4'd1 << dims;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            dlo[a]   = {pt_in[a][VW-1], pt_in[a]} - {lo_in[a][VW-1], lo_in[a]};
            dhi[a]   = {pt_in[a][VW-1], pt_in[a]} - {hi_in[a][VW-1], hi_in[a]};
            dl[a]    = dlo[a][VW] ? -dlo[a] : dlo[a];
            dh[a]    = dhi[a][VW] ? -dhi[a] : dhi[a];
            ok_lo[a] = dl[a] <= dh[a];
            ok_hi[a] = dh[a] <= dl[a];
        end
        for (int i = 0; i < 8; i++) begin
            hit[i] = 4'(i) < n_val;
            for (int a = 0; a < 3; a++) begin
                if (2'(a) < dims && !(ctrl_in.mask[i][a] ? ok_hi[a] : ok_lo[a])) begin
                    hit[i] = 1'b0;
                end
            end
        end
        // lowest corner index wins a tie
        q = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (hit[i]) begin
                q = 3'(i);
            end
        end
        mq = ctrl_in.mask[q];
        for (int a = 0; a < 3; a++) begin
            vv[a]  = mq[a] ? hi_in[a] : lo_in[a];
            ww[a]  = mq[a] ? lo_in[a] : hi_in[a];
            sum[a] = {vv[a][VW-1], vv[a]} + {ww[a][VW-1], ww[a]};
        end
        ctrl_next = ctrl_in;
        lo_next   = lo_in;
        hi_next   = hi_in;
        jj        = 3'd0;
        if (active) begin
            for (int a = 0; a < 3; a++) begin
                lo_next[a] = vv[a];
                hi_next[a] = sum[a][VW:1];
            end
            for (int i = 0; i < 8; i++) begin
                jj = hke_pkg::sub_entry(dims, q, 3'(i)) & 3'(n_val - 4'd1);
                ctrl_next.mask[i] = ctrl_in.mask[jj] ^ mq;
            end
            ctrl_next.key = (ctrl_in.key << dims) | hke_pkg::KEY_W'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            ctrl_reg.valid <= ctrl_next.valid;
        end
        if (en) begin
            ctrl_reg.mask <= ctrl_next.mask;
            ctrl_reg.key  <= ctrl_next.key;
            pt_reg        <= pt_in;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
        end
    end

endmodule

@@ hw/rtl/hilbert_key_encoder_unit.sv @@
// Top level of the Hilbert key encoder: config registers and the cell chain.
// Depends on hke_pkg and hke_cell.
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_x_coord, s_y_coord, s_z_coord
//  m_       out        m_valid / m_ready    m_curve_key
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wdata
//
// One item per cycle while the output is not stalled; the chain has one registered cell per level.
// Levels beyond level_count pass the item through their cell unchanged.
// The whole chain advances together; it stalls only while m_valid waits on m_ready.
// Reset clears all valid bits and loads the register defaults.
module hilbert_key_encoder_unit #(
    parameter int MAX_LEVELS  = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_x_coord,
    input  logic signed [COORD_WIDTH-1:0] s_y_coord,
    input  logic signed [COORD_WIDTH-1:0] s_z_coord,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hke_pkg::KEY_W-1:0]   m_curve_key,
    input  logic                        cfg_wr_en,
    input  logic [2:0]                  cfg_index,
    input  logic [COORD_WIDTH-1:0]      cfg_wdata
);

    // coordinates carry MAX_LEVELS fraction bits so every midpoint is exact
    localparam int VW = COORD_WIDTH + MAX_LEVELS;

    logic [1:0]                  dims_reg;
    logic [4:0]                  level_reg;
    logic [2:0][COORD_WIDTH-1:0] min_reg, max_reg;
    logic [4:0]                  levels_sat;
    logic                        en;

    hke_pkg::hke_ctrl_t          ctrl  [MAX_LEVELS+1];
    logic [2:0][VW-1:0]          pt    [MAX_LEVELS+1];
    logic [2:0][VW-1:0]          lo    [MAX_LEVELS+1];
    logic [2:0][VW-1:0]          hi    [MAX_LEVELS+1];

    // Configuration writes; out-of-list indexes do not exist with 3 index bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg  <= 2'd2;
            level_reg <= 5'd10;
            min_reg   <= '0;
            max_reg   <= {3{COORD_WIDTH'(65535)}};
        end else if (cfg_wr_en) begin
            unique case (hke_pkg::hke_reg_t'(cfg_index))
                hke_pkg::REG_DIMENSIONS:  dims_reg   <= cfg_wdata[1:0];
                hke_pkg::REG_LEVEL_COUNT: level_reg  <= cfg_wdata[4:0];
                hke_pkg::REG_MIN_X:       min_reg[0] <= cfg_wdata;
                hke_pkg::REG_MIN_Y:       min_reg[1] <= cfg_wdata;
                hke_pkg::REG_MIN_Z:       min_reg[2] <= cfg_wdata;
                hke_pkg::REG_MAX_X:       max_reg[0] <= cfg_wdata;
                hke_pkg::REG_MAX_Y:       max_reg[1] <= cfg_wdata;
                hke_pkg::REG_MAX_Z:       max_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Saturate the level count to the chain length.
    assign levels_sat = (level_reg > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : level_reg;

    // Advance the chain whenever the output slot is free or being taken.
    assign en      = !ctrl[MAX_LEVELS].valid || m_ready;
    assign s_ready = en;

    // Entry: scale the point and bounds, seed the corner labels.
    always_comb begin
        ctrl[0].valid = s_valid;
        ctrl[0].key   = '0;
        for (int i = 0; i < hke_pkg::NUM_CORNERS; i++) begin
            ctrl[0].mask[i] = hke_pkg::high_mask(dims_reg, 3'(i));
        end
        pt[0][0] = {s_x_coord, {MAX_LEVELS{1'b0}}};
        pt[0][1] = {s_y_coord, {MAX_LEVELS{1'b0}}};
        pt[0][2] = {s_z_coord, {MAX_LEVELS{1'b0}}};
        for (int a = 0; a < hke_pkg::NUM_AXES; a++) begin
            lo[0][a] = {min_reg[a], {MAX_LEVELS{1'b0}}};
            hi[0][a] = {max_reg[a], {MAX_LEVELS{1'b0}}};
        end
    end

    for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
        hke_cell #(
            .VW        (VW),
            .LEVEL_IDX (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .dims     (dims_reg),
            .levels   (levels_sat),
            .ctrl_in  (ctrl[k]),
            .pt_in    (pt[k]),
            .lo_in    (lo[k]),
            .hi_in    (hi[k]),
            .ctrl_reg (ctrl[k+1]),
            .pt_reg   (pt[k+1]),
            .lo_reg   (lo[k+1]),
            .hi_reg   (hi[k+1])
        );
    end

    assign m_valid     = ctrl[MAX_LEVELS].valid;
    assign m_curve_key = ctrl[MAX_LEVELS].key;

    // Zero dimensions produce an all-zero key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && dims_reg == 2'd0 |-> m_curve_key == '0)
        else $error("nonzero key with zero dimensions");

    // A single one-dimensional level yields a one-bit key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && dims_reg == 2'd1 && levels_sat == 5'd1 |-> m_curve_key[47:1] == '0)
        else $error("key wider than one digit");

    // Key never exceeds dimensions times levels bits for the reset setup.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && dims_reg == 2'd2 && levels_sat == 5'd10 |-> m_curve_key[47:20] == '0)
        else $error("key exceeds digit count");

    // Nothing leaves the chain right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

@@ sim/hilbert_key_encoder_unit_tb.sv @@
// Self-checking testbench for hilbert_key_encoder_unit: random and directed points
// over several box and level settings, keys checked against an in-bench predictor.
// Depends on hke_pkg and the encoder RTL.
`timescale 1ns / 1ps

module hilbert_key_encoder_unit_tb;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [31:0]        s_x_coord = '0;
    logic signed [31:0]        s_y_coord = '0;
    logic signed [31:0]        s_z_coord = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [hke_pkg::KEY_W-1:0] m_curve_key;
    logic                      cfg_wr_en = 1'b0;
    logic [2:0]                cfg_index = '0;
    logic [31:0]               cfg_wdata = '0;

    // Mirror of the block's registers, updated as they are written.
    logic [1:0]         dims_r = 2'd2;
    logic [4:0]         levels_r = 5'd10;
    logic signed [31:0] box_min [3] = '{0, 0, 0};
    logic signed [31:0] box_max [3] = '{65535, 65535, 65535};

    point_t                    pending_points [$];
    logic [hke_pkg::KEY_W-1:0] expected_keys [$];
    int                        error_count = 0;
    int                        cycle_count = 0;
    bit                        calm = 1'b0;     // no idling on either side
    bit                        hold_off = 1'b0; // sender holds back new items

    hilbert_key_encoder_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_x_coord(s_x_coord), .s_y_coord(s_y_coord), .s_z_coord(s_z_coord),
        .m_valid(m_valid), .m_ready(m_ready), .m_curve_key(m_curve_key),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Key the block should give for one point under the mirrored registers.
    function automatic logic [hke_pkg::KEY_W-1:0] hilbert_key(point_t p);
        longint     c [8][3];
        longint     nx [8][3];
        longint     pt [3];
        longint     best [3];
        longint     d;
        logic [63:0] key;
        int         n, lvls, q, j;
        bit         hit;
        logic [2:0] hm;
        key = '0;
        lvls = (levels_r > 16) ? 16 : levels_r;
        if (dims_r == 2'd0 || lvls == 0) return '0;
        n = 1 << dims_r;
        pt[0] = longint'(p.x) * 65536;
        pt[1] = longint'(p.y) * 65536;
        pt[2] = longint'(p.z) * 65536;
        for (int i = 0; i < n; i++) begin
            hm = (dims_r == 2'd1) ? hke_pkg::HIGH1[i] :
                 (dims_r == 2'd2) ? hke_pkg::HIGH2[i] : hke_pkg::HIGH3[i];
            for (int a = 0; a < 3; a++)
                c[i][a] = longint'(hm[a] ? box_max[a] : box_min[a]) * 65536;
        end
        for (int l = 0; l < lvls; l++) begin
            // Nearest corner per axis, then the lowest label matching all axes.
            for (int a = 0; a < dims_r; a++) begin
                best[a] = -1;
                for (int i = 0; i < n; i++) begin
                    d = pt[a] - c[i][a];
                    if (d < 0) d = -d;
                    if (best[a] < 0 || d < best[a]) best[a] = d;
                end
            end
            q = 0;
            for (int i = n - 1; i >= 0; i--) begin
                hit = 1'b1;
                for (int a = 0; a < dims_r; a++) begin
                    d = pt[a] - c[i][a];
                    if (d < 0) d = -d;
                    if (d != best[a]) hit = 1'b0;
                end
                if (hit) q = i;
            end
            key = (key << dims_r) | 64'(q);
            for (int i = 0; i < n; i++) begin
                j = (dims_r == 2'd1) ? hke_pkg::SUB1[q][i] :
                    (dims_r == 2'd2) ? hke_pkg::SUB2[q][i] : hke_pkg::SUB3[q][i];
                j = j & (n - 1);
                for (int a = 0; a < 3; a++) nx[i][a] = (c[q][a] + c[j][a]) / 2;
            end
            c = nx;
        end
        return key[hke_pkg::KEY_W-1:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Driver: predict each accepted item, then present the next one or drop valid.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            point_t nxt;
            bit     go;
            go = !hold_off && pending_points.size() > 0
                 && (calm || $urandom_range(99) >= 10);
            if (s_valid && s_ready) begin
                nxt.x = s_x_coord; nxt.y = s_y_coord; nxt.z = s_z_coord;
                expected_keys.push_back(hilbert_key(nxt));
            end
            if (!s_valid || s_ready) begin
                if (go) begin
                    nxt = pending_points.pop_front();
                    s_x_coord <= nxt.x;
                    s_y_coord <= nxt.y;
                    s_z_coord <= nxt.z;
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each accepted key with the oldest expected.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_keys.size() == 0)
                    report_mismatch($sformatf("unexpected key %h", m_curve_key));
                else begin
                    logic [hke_pkg::KEY_W-1:0] want;
                    want = expected_keys.pop_front();
                    if (want !== m_curve_key)
                        report_mismatch($sformatf("curve_key %h, expected %h",
                                                  m_curve_key, want));
                end
            end
            m_ready <= calm || $urandom_range(99) >= 10;
        end
        if (cycle_count > 400000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(hke_pkg::hke_reg_t idx, logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            hke_pkg::REG_DIMENSIONS:  dims_r = value[1:0];
            hke_pkg::REG_LEVEL_COUNT: levels_r = value[4:0];
            hke_pkg::REG_MIN_X:       box_min[0] = value;
            hke_pkg::REG_MIN_Y:       box_min[1] = value;
            hke_pkg::REG_MIN_Z:       box_min[2] = value;
            hke_pkg::REG_MAX_X:       box_max[0] = value;
            hke_pkg::REG_MAX_Y:       box_max[1] = value;
            hke_pkg::REG_MAX_Z:       box_max[2] = value;
            default: ;
        endcase
    endtask

    // Block until every queued item is in and every key is back, plus a drain margin.
    task automatic wait_idle();
        while (pending_points.size() > 0 || s_valid || expected_keys.size() > 0)
            @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_coord(int axis);
        longint lo, hi;
        lo = box_min[axis];
        hi = box_max[axis];
        if (lo > hi) begin lo = box_max[axis]; hi = box_min[axis]; end
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return (($urandom_range(1)) ? box_min[axis] : box_max[axis]);
            2:       return 32'(lo + (hi - lo) / 2);
            default: return 32'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
        endcase
    endfunction

    task automatic push_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        point_t p;
        p.x = x; p.y = y; p.z = z;
        pending_points.push_back(p);
    endtask

    initial begin
        logic [31:0] mins [3];
        logic [31:0] maxs [3];
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed points at the reset settings: extremes, corners, midpoint.
        push_point(0, 0, 0);
        push_point(65535, 65535, 0);
        push_point(0, 65535, 0);
        push_point(65535, 0, 0);
        push_point(32767, 32768, 0);
        push_point(32767, 32767, 0);
        push_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        push_point(32'h80000000, 32'h80000000, 32'h80000000);
        push_point(32'h80000000, 32'h7fffffff, 0);
        push_point(-1, -1, -1);
        wait_idle();

        for (int ph = 0; ph < 14; ph++) begin
            // Box shapes: full range, inverted, degenerate, random, small range around zero.
            for (int a = 0; a < 3; a++) begin
                case (ph % 5)
                    0: begin mins[a] = 32'h80000000; maxs[a] = 32'h7fffffff; end
                    1: begin
                        mins[a] = $urandom_range(60000, 10000);
                        maxs[a] = -$urandom_range(9000);
                    end
                    2: begin mins[a] = $urandom; maxs[a] = mins[a]; end
                    3: begin mins[a] = $urandom; maxs[a] = $urandom; end
                    default: begin
                        mins[a] = -$urandom_range(1000);
                        maxs[a] = $urandom_range(5000);
                    end
                endcase
            end
            write_reg(hke_pkg::REG_DIMENSIONS,
                32'({$urandom, 2'(ph % 4 == 0 ? 3 : ph % 4)}
                    & (ph == 7 ? 32'hfffffffc : 32'hffffffff)));
            write_reg(hke_pkg::REG_LEVEL_COUNT, 32'({$urandom,
                5'(ph == 3 ? 0 : ph == 5 ? 31 : ph == 9 ? 1 : ph % 2 ? 16
                   : $urandom_range(1, 20))}));
            write_reg(hke_pkg::REG_MIN_X, mins[0]);
            write_reg(hke_pkg::REG_MIN_Y, mins[1]);
            write_reg(hke_pkg::REG_MIN_Z, mins[2]);
            write_reg(hke_pkg::REG_MAX_X, maxs[0]);
            write_reg(hke_pkg::REG_MAX_Y, maxs[1]);
            write_reg(hke_pkg::REG_MAX_Z, maxs[2]);
            calm = (ph == 4);
            if (ph == 0) begin
                push_point(32'h80000000, 32'h80000000, 32'h80000000);
                push_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
                push_point(0, 0, 0);
            end
            for (int k = 0; k < 46; k++) begin
                push_point(rand_coord(0), rand_coord(1), rand_coord(2));
                if (ph == 6 && k == 20) begin
                    // Hold the sender back until every key has come out.
                    while (pending_points.size() > 0) @(posedge aclk);
                    hold_off = 1'b1;
                    while (s_valid || expected_keys.size() > 0) @(posedge aclk);
                    repeat (5) @(posedge aclk);
                    hold_off = 1'b0;
                end
            end
            wait_idle();
        end
        calm = 1'b0;

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/hke_pkg.sv
hw/rtl/hke_cell.sv
hw/rtl/hilbert_key_encoder_unit.sv
sim/hilbert_key_encoder_unit_tb.sv
